[sv/rgbads_pkg.sv]
// Package with the constants, register indexes and types of the RGBA 2x2 box downsampler.
package rgbads_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    localparam int DIM_W    = 13;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int ADDR_W   = $clog2(LINE_DEPTH);
    localparam int CHAN_N   = 4;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = CHAN_N * CHAN_W;
    localparam int PAIR_W   = CHAN_W + 1;
    localparam int LINE_W   = CHAN_N * PAIR_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWNSAMPLE_ENABLE = 2'd2;

    localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT = DIM_W'(480);

    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [LINE_W-1:0] t_pair_sums;

    function automatic t_dim clamp_dim(input t_dim value, input t_dim limit);
        t_dim result;
        if (value == '0) begin
            result = DIM_W'(1);
        end else if (value > limit) begin
            result = limit;
        end else begin
            result = value;
        end
        return result;
    endfunction

endpackage

[sv/rgbads_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module rgbads_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/rgba_2x2_box_downsampler.sv]
// Top level of the RGBA 2x2 box downsampler with its counters, line store and result register.
//
// Pixels enter on the s_axis channel in raster order, one request per pixel, and
// results leave on the m_axis channel. With downsampling enabled, even rows store
// horizontal pair sums in a half-width line store, and each odd column of an odd
// row emits the truncated average of its 2x2 block; an odd last column or row
// gives no result. With downsampling disabled every pixel passes through. The
// m_axis_tlast bit marks the last result of a frame.
// The block accepts one pixel per clock while s_axis_tready is high. Each pixel
// passes the r1 stage, beside the line store read register, then the result register.
// The user must write the configuration port only while the block is idle; the block
// does not enforce it. Any listed register write restarts the frame at row zero, column zero.
// Reset restores the register defaults (640 by 480, downsampling on), clears
// the counters and empties the pipeline; the line store is not cleared.
// When the receiver stalls, the result register holds and the pipeline stage
// behind it fills, after which s_axis_tready drops until the result is taken.
module rgba_2x2_box_downsampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rgbads_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgbads_pkg::DIM_W-1:0]   i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: red_in, green_in, blue_in, alpha_in.
    input  logic [rgbads_pkg::PIX_W-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: red_out, green_out, blue_out, alpha_out.
    output logic [rgbads_pkg::PIX_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tlast
);

    import rgbads_pkg::*;

    t_dim              r_frame_width;
    t_dim              r_frame_height;
    logic              r_downsample;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    t_pixel            r_left;
    logic              r1_valid;
    logic              r1_avg;
    logic              r1_last;
    t_pair_sums        r1_data;
    logic              r_out_valid;
    logic              r_out_last;
    t_pixel            r_out_data;

    t_dim              w_eff;
    t_dim              h_eff;
    t_dim              w_even;
    t_dim              h_even;
    t_dim              col_ext;
    t_dim              row_ext;
    logic              col_last;
    logic              row_last;
    logic              in_block;
    logic              accept;
    logic              advance;
    logic              emit;
    logic              line_wr;
    logic              line_rd;
    logic              cfg_restart;
    logic              n_last;
    t_pair_sums        pair;
    t_pair_sums        n_data;
    t_pair_sums        line_rd_data;
    logic [ADDR_W-1:0] line_addr;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    t_pixel            avg;

    assign w_eff   = clamp_dim(r_frame_width, DIM_W'(MAX_WIDTH));
    assign h_eff   = clamp_dim(r_frame_height, DIM_W'(MAX_HEIGHT));
    assign w_even  = {w_eff[DIM_W-1:1], 1'b0};
    assign h_even  = {h_eff[DIM_W-1:1], 1'b0};
    assign col_ext = DIM_W'(r_col);
    assign row_ext = DIM_W'(r_row);
    assign col_last = (col_ext == w_eff - DIM_W'(1));
    assign row_last = (row_ext == h_eff - DIM_W'(1));
    assign in_block = (col_ext < w_even) && (row_ext < h_even);

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r1_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign line_addr = r_col[COL_W-1:1];
    assign line_wr   = accept && r_downsample && in_block && r_col[0] && !r_row[0];
    assign line_rd   = accept && r_downsample && in_block && r_col[0] && r_row[0];
    assign emit      = !r_downsample || (in_block && r_col[0] && r_row[0]);

    assign cfg_restart = i_cfg_wr_en && ((i_cfg_index == CFG_FRAME_WIDTH)
        || (i_cfg_index == CFG_FRAME_HEIGHT) || (i_cfg_index == CFG_DOWNSAMPLE_ENABLE));

    always_comb begin
        for (int k = 0; k < CHAN_N; k++) begin
            pair[k*PAIR_W +: PAIR_W] = PAIR_W'(r_left[k*CHAN_W +: CHAN_W])
                                     + PAIR_W'(s_axis_tdata[k*CHAN_W +: CHAN_W]);
        end
    end

    always_comb begin
        if (r_downsample) begin
            n_data = pair;
            n_last = (row_ext == h_even - DIM_W'(1)) && (col_ext == w_even - DIM_W'(1));
        end else begin
            n_data = LINE_W'(s_axis_tdata);
            n_last = row_last && col_last;
        end
    end

    always_comb begin
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_comb begin
        for (int k = 0; k < CHAN_N; k++) begin
            avg[k*CHAN_W +: CHAN_W] = CHAN_W'(((PAIR_W + 1)'(line_rd_data[k*PAIR_W +: PAIR_W])
                + (PAIR_W + 1)'(r1_data[k*PAIR_W +: PAIR_W])) >> 2);
        end
    end

    rgbads_ram #(
        .WIDTH(LINE_W),
        .DEPTH(LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_wr_addr (line_addr),
        .i_wr_data (pair),
        .i_rd_en   (line_rd),
        .i_rd_addr (line_addr),
        .o_rd_data (line_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_FRAME_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
            r_downsample   <= 1'b1;
            r_col          <= '0;
            r_row          <= '0;
            r1_valid       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data;
                    end
                    CFG_DOWNSAMPLE_ENABLE: begin
                        r_downsample <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r1_valid <= emit;
            end else if (advance) begin
                r1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_downsample && in_block && !r_col[0]) begin
            r_left <= s_axis_tdata;
        end
        if (accept) begin
            r1_avg  <= r_downsample;
            r1_last <= n_last;
            r1_data <= n_data;
        end
        if (advance && r1_valid) begin
            r_out_last <= r1_last;
            r_out_data <= r1_avg ? avg : r1_data[PIX_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

[sv/rgbads_checker.sv]
// Port-level assertions for the RGBA 2x2 box downsampler and the bind that attaches them.
module rgbads_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [rgbads_pkg::PIX_W-1:0]     m_axis_tdata,
    input  logic                             m_axis_tlast
);

    import rgbads_pkg::*;

    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("Result valid right after reset.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("Input stalled while the receiver is ready.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("Result appeared without a request two cycles before.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result request withdrawn while stalled.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Result changed while stalled.");

endmodule

bind rgba_2x2_box_downsampler rgbads_checker u_rgbads_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
